// ===== design/lru_pkg.sv =====
`timescale 1ns / 1ps

package lru_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESP
   } state_type;

   localparam int unsigned CSR_BITS = 4;
   localparam logic [CSR_BITS-1:0] CSR_RESET = 4'd4;

endpackage

// ===== design/lru_ram.sv =====
`timescale 1ns / 1ps

module lru_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 8,
   parameter int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lru_page_replacement.sv =====
`timescale 1ns / 1ps
// With n active frames, a request runs a read-pipelined scan pass and then an update pass
// over the frame RAM, each covering the n active frames, before rsp_valid is raised.
// A new request is taken only after the last response is taken; req_ready is high only when idle.
// Frame page/age words live in a single-port-write RAM, one frame read per cycle.
// Reset (sync, active high): all frames empty, fault count zero, active_frames = 4.
module lru_page_replacement #(
   parameter int unsigned MAX_FRAMES = 8,
   parameter int unsigned PAGE_BITS  = 8,
   parameter int unsigned AGE_BITS   = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_wr_en,
   input  logic [lru_pkg::CSR_BITS-1:0]                  csr_wr_data,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic [PAGE_BITS-1:0]                          req_page,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic                                          rsp_hit,
   output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] rsp_slot,
   output logic                                          rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]                          rsp_evicted_page,
   output logic [31:0]                                   rsp_fault_count
);
   import lru_pkg::*;

   localparam int unsigned SLOT_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int unsigned CNT_BITS  = $clog2(MAX_FRAMES + 1);
   localparam int unsigned WORD_BITS = PAGE_BITS + AGE_BITS;

   state_type               state_ff, state_in;
   logic [CSR_BITS-1:0]     csr_ff;
   logic [MAX_FRAMES-1:0]   valid_ff, valid_in;
   logic [31:0]             faults_ff, faults_in;
   logic [CNT_BITS-1:0]     idx_ff, idx_in;
   logic [CNT_BITS-1:0]     n_ff, n_in;
   logic                    dv_ff, dv_in;
   logic [SLOT_BITS-1:0]    didx_ff, didx_in;
   logic [PAGE_BITS-1:0]    pg_ff, pg_in;
   logic                    hit_ff, hit_in;
   logic [SLOT_BITS-1:0]    hslot_ff, hslot_in;
   logic                    empty_ff, empty_in;
   logic                    have_ff, have_in;
   logic [SLOT_BITS-1:0]    vslot_ff, vslot_in;
   logic [AGE_BITS-1:0]     bage_ff, bage_in;
   logic [PAGE_BITS-1:0]    bpage_ff, bpage_in;

   logic [CNT_BITS-1:0]     n_calc;
   logic                    ram_we;
   logic [WORD_BITS-1:0]    ram_wdata, ram_rdata;
   logic                    f_valid, f_match, is_victim;
   logic [PAGE_BITS-1:0]    f_page, new_page;
   logic [AGE_BITS-1:0]     f_age, new_age;

   lru_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(MAX_FRAMES),
      .ADDR_BITS(SLOT_BITS)
   ) u_frames (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(didx_ff),
      .wr_data(ram_wdata),
      .rd_addr(idx_ff[SLOT_BITS-1:0]),
      .rd_data(ram_rdata)
   );

   always_comb begin
      if (csr_ff == '0) begin
         n_calc = CNT_BITS'(1);
      end else if (32'(csr_ff) > 32'(MAX_FRAMES)) begin
         n_calc = CNT_BITS'(MAX_FRAMES);
      end else begin
         n_calc = CNT_BITS'(csr_ff);
      end
   end

   assign f_page    = ram_rdata[WORD_BITS-1:AGE_BITS];
   assign f_age     = ram_rdata[AGE_BITS-1:0];
   assign f_valid   = valid_ff[didx_ff];
   assign f_match   = f_valid && (f_page == pg_ff);
   assign is_victim = !hit_ff && (didx_ff == vslot_ff);

   always_comb begin
      new_age = f_age;
      if (f_valid && (f_age != {AGE_BITS{1'b1}})) begin
         new_age = f_age + 1'b1;
      end
      if (hit_ff ? f_match : is_victim) begin
         new_age = '0;
      end
      new_page  = is_victim ? pg_ff : f_page;
      ram_wdata = {new_page, new_age};
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      faults_in = faults_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      dv_in = 1'b0;
      didx_in = idx_ff[SLOT_BITS-1:0];
      pg_in = pg_ff;
      hit_in = hit_ff;
      hslot_in = hslot_ff;
      empty_in = empty_ff;
      have_in = have_ff;
      vslot_in = vslot_ff;
      bage_in = bage_ff;
      bpage_in = bpage_ff;
      ram_we = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pg_in = req_page;
               n_in = n_calc;
               idx_in = '0;
               hit_in = 1'b0;
               empty_in = 1'b0;
               have_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff != n_ff) begin
               idx_in = idx_ff + 1'b1;
               dv_in = 1'b1;
            end
            if (dv_ff) begin
               if (f_match && !hit_ff) begin
                  hit_in = 1'b1;
                  hslot_in = didx_ff;
               end
               if (!empty_ff) begin
                  if (!f_valid) begin
                     empty_in = 1'b1;
                     vslot_in = didx_ff;
                  end else if (!have_ff || (f_age > bage_ff)) begin
                     have_in = 1'b1;
                     vslot_in = didx_ff;
                     bage_in = f_age;
                     bpage_in = f_page;
                  end
               end
            end
            if (idx_ff == n_ff) begin
               idx_in = '0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (idx_ff != n_ff) begin
               idx_in = idx_ff + 1'b1;
               dv_in = 1'b1;
            end
            ram_we = dv_ff;
            if (idx_ff == n_ff) begin
               state_in = ST_RESP;
               if (!hit_ff) begin
                  faults_in = faults_ff + 1'b1;
                  valid_in[vslot_ff] = 1'b1;
               end
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         csr_ff <= CSR_RESET;
         valid_ff <= '0;
         faults_ff <= '0;
         dv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         valid_ff <= valid_in;
         faults_ff <= faults_in;
         dv_ff <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      n_ff <= n_in;
      didx_ff <= didx_in;
      pg_ff <= pg_in;
      hit_ff <= hit_in;
      hslot_ff <= hslot_in;
      empty_ff <= empty_in;
      have_ff <= have_in;
      vslot_ff <= vslot_in;
      bage_ff <= bage_in;
      bpage_ff <= bpage_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = (state_ff == ST_RESP);
   assign rsp_hit           = hit_ff;
   assign rsp_slot          = hit_ff ? hslot_ff : vslot_ff;
   assign rsp_evicted_valid = !hit_ff && !empty_ff;
   assign rsp_evicted_page  = rsp_evicted_valid ? bpage_ff : '0;
   assign rsp_fault_count   = faults_ff;

`ifndef ASSERT_OFF
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response both open");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_UPDATE) |-> (idx_ff <= n_ff))
      else $error("frame index past active count");

   a_fault_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid) && !rsp_hit) |->
         (rsp_fault_count == 32'($past(faults_ff) + 1'b1)))
      else $error("fault count not advanced on miss");

   a_victim_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> valid_ff[rsp_slot])
      else $error("victim frame not marked valid");
`endif

endmodule
